>>> src/rhkv_pkg.sv
// Shared types, constants and codes for the Robin Hood key/value table.
// Used by the channel interfaces, the hash unit, the slot store and the top level.
// No dependencies.
package rhkv_pkg;

  // Table geometry (SLOTS must be a power of two: home slot is the low hash bits)
  localparam int SLOTS      = 1024;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int CNT_BITS   = SLOT_BITS + 1;
  localparam int KEY_BITS   = 64;
  localparam int KEY_BYTES  = 8;
  localparam int VALUE_BITS = 32;
  localparam int HASH_BITS  = 32;
  localparam int BCNT_BITS  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  localparam logic [KEY_BITS-1:0] KEY_MASK = {KEY_BITS{1'b1}} >> (KEY_BITS - 8 * KEY_BYTES);

  // FNV-1a 32-bit constants
  localparam logic [HASH_BITS-1:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [HASH_BITS-1:0] FNV_PRIME  = 32'd16777619;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FIND,
    S_INSERT,
    S_RESP
  } state_t;

  // One stored slot
  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [SLOT_BITS-1:0]  distance;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

endpackage

>>> src/rhkv_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on rhkv_pkg for field widths.
interface rhkv_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [rhkv_pkg::KEY_BITS-1:0]  key;
  logic [rhkv_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface rhkv_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [rhkv_pkg::VALUE_BITS-1:0] value_out;
  logic [rhkv_pkg::CNT_BITS-1:0]   entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

>>> src/rhkv_hash.sv
// Iterative FNV-1a hash unit: one key byte per cycle through one 32x32 multiplier.
// Depends on rhkv_pkg.
module rhkv_hash (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rhkv_pkg::KEY_BITS-1:0]    key,
  output logic                             done,
  output logic [rhkv_pkg::HASH_BITS-1:0]   hash
);

  logic                             busy;
  logic [rhkv_pkg::BCNT_BITS-1:0]   bcnt;
  logic [rhkv_pkg::KEY_BITS-1:0]    key_sh;
  logic [rhkv_pkg::HASH_BITS-1:0]   h_x;
  logic [rhkv_pkg::HASH_BITS-1:0]   h_mul;

  // Fold in the low byte, then multiply by the prime (kept to 32 bits)
  assign h_x   = hash ^ {{(rhkv_pkg::HASH_BITS-8){1'b0}}, key_sh[7:0]};
  assign h_mul = h_x * rhkv_pkg::FNV_PRIME;

  // Control: run KEY_BYTES steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bcnt <= '0;
      end else if (busy) begin
        bcnt <= bcnt + 1'b1;
        if (bcnt == rhkv_pkg::BCNT_BITS'(rhkv_pkg::KEY_BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load offset and key, then advance one byte a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      hash   <= rhkv_pkg::FNV_OFFSET;
      key_sh <= key;
    end else if (busy) begin
      hash   <= h_mul;
      key_sh <= key_sh >> 8;
    end
  end

endmodule

>>> src/rhkv_store.sv
// Slot store: one write port and one read port with registered read data.
// Depends on rhkv_pkg for the slot layout and depth.
module rhkv_store (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [rhkv_pkg::SLOT_BITS-1:0]  wr_addr,
  input  rhkv_pkg::slot_t                 wr_data,
  input  logic [rhkv_pkg::SLOT_BITS-1:0]  rd_addr,
  output rhkv_pkg::slot_t                 rd_data
);

  rhkv_pkg::slot_t mem [rhkv_pkg::SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/robin_hood_key_value_table_unit.sv
// Robin Hood key/value table: FNV-1a hash unit, slot store and probe sequencer.
// Depends on rhkv_pkg, rhkv_if, rhkv_hash and rhkv_store.
// Flow: accept, hash (8 multiplies, one per key byte, then done), search over the probed
// slots, on insert a walk over the slots from home, then the response. One transaction
// is in flight at a time. Reset: synchronous; afterwards a clearing pass (one slot a
// cycle) empties the store before the first request is taken.
module robin_hood_key_value_table_unit (
  input  logic        clk,
  input  logic        rst,
  rhkv_req_if.sink    req,
  rhkv_rsp_if.source  rsp
);

  localparam logic [rhkv_pkg::SLOT_BITS-1:0] LAST_SLOT =
    rhkv_pkg::SLOT_BITS'(rhkv_pkg::SLOTS - 1);
  localparam logic [rhkv_pkg::CNT_BITS-1:0]  FULL_COUNT =
    rhkv_pkg::CNT_BITS'(rhkv_pkg::SLOTS);

  rhkv_pkg::state_t                  state, state_next;
  logic [rhkv_pkg::SLOT_BITS-1:0]    idx, idx_next;
  logic [rhkv_pkg::SLOT_BITS-1:0]    probe_dist, probe_dist_next;
  logic [rhkv_pkg::SLOT_BITS-1:0]    home, home_next;
  logic [rhkv_pkg::CNT_BITS-1:0]     count, count_next;
  logic                              op;
  logic [rhkv_pkg::KEY_BITS-1:0]     cur_key, cur_key_next;
  logic [rhkv_pkg::VALUE_BITS-1:0]   cur_val, cur_val_next;
  rhkv_pkg::status_t                 res_status, res_status_next;
  logic [rhkv_pkg::VALUE_BITS-1:0]   res_value, res_value_next;
  logic                              out_valid, out_valid_next;
  logic                              out_load;
  rhkv_pkg::status_t                 out_status;
  logic [rhkv_pkg::VALUE_BITS-1:0]   out_value;
  logic [rhkv_pkg::CNT_BITS-1:0]     out_count;

  logic                              accept;
  logic                              hash_done;
  logic [rhkv_pkg::HASH_BITS-1:0]    hash;
  logic                              wr_en;
  rhkv_pkg::slot_t                   wr_data;
  rhkv_pkg::slot_t                   rd;
  logic                              probe_stop;
  logic                              probe_hit;

  assign req.ready = (state == rhkv_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.value_out   = out_value;
  assign rsp.entry_count = out_count;

  rhkv_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (req.key & rhkv_pkg::KEY_MASK),
    .done  (hash_done),
    .hash  (hash)
  );

  rhkv_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (idx_next),
    .rd_data (rd)
  );

  // Search ends at an empty slot or a resident closer to home than the probe
  assign probe_stop = !rd.valid || (probe_dist > rd.distance);
  assign probe_hit  = !probe_stop && (rd.key == cur_key);

  // Next state, slot writes and result selection
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    probe_dist_next = probe_dist;
    home_next       = home;
    count_next      = count;
    cur_key_next    = cur_key;
    cur_val_next    = cur_val;
    res_status_next = res_status;
    res_value_next  = res_value;
    out_load        = 1'b0;
    wr_en           = 1'b0;
    wr_data         = '{valid: 1'b1, key: cur_key, distance: probe_dist, value: cur_val};

    unique case (state)
      rhkv_pkg::S_CLEAR: begin
        // Empty one slot a cycle
        wr_en         = 1'b1;
        wr_data.valid = 1'b0;
        idx_next      = idx + 1'b1;
        if (idx == LAST_SLOT) begin
          state_next = rhkv_pkg::S_IDLE;
        end
      end

      rhkv_pkg::S_IDLE: begin
        if (accept) begin
          cur_key_next = req.key & rhkv_pkg::KEY_MASK;
          cur_val_next = req.value;
          state_next   = rhkv_pkg::S_HASH;
        end
      end

      rhkv_pkg::S_HASH: begin
        // Start the search at the home slot
        if (hash_done) begin
          home_next       = hash[rhkv_pkg::SLOT_BITS-1:0];
          idx_next        = hash[rhkv_pkg::SLOT_BITS-1:0];
          probe_dist_next = '0;
          state_next      = rhkv_pkg::S_FIND;
        end
      end

      rhkv_pkg::S_FIND: begin
        if (probe_hit) begin
          if (op == rhkv_pkg::OP_GET) begin
            res_status_next = rhkv_pkg::ST_OK;
            res_value_next  = rd.value;
          end else begin
            res_status_next = rhkv_pkg::ST_MISS;
            res_value_next  = '0;
          end
          state_next = rhkv_pkg::S_RESP;
        end else if (probe_stop || probe_dist == LAST_SLOT) begin
          res_value_next = '0;
          if (op == rhkv_pkg::OP_GET) begin
            res_status_next = rhkv_pkg::ST_MISS;
            state_next      = rhkv_pkg::S_RESP;
          end else if (count == FULL_COUNT) begin
            res_status_next = rhkv_pkg::ST_FULL;
            state_next      = rhkv_pkg::S_RESP;
          end else begin
            // Restart from home for the insert walk
            idx_next        = home;
            probe_dist_next = '0;
            state_next      = rhkv_pkg::S_INSERT;
          end
        end else begin
          idx_next        = idx + 1'b1;
          probe_dist_next = probe_dist + 1'b1;
        end
      end

      rhkv_pkg::S_INSERT: begin
        if (!rd.valid) begin
          // Drop the carried entry into the empty slot
          wr_en           = 1'b1;
          count_next      = count + 1'b1;
          res_status_next = rhkv_pkg::ST_OK;
          res_value_next  = '0;
          state_next      = rhkv_pkg::S_RESP;
        end else if (probe_dist > rd.distance) begin
          // Swap with the richer resident and carry it on
          wr_en           = 1'b1;
          cur_key_next    = rd.key;
          cur_val_next    = rd.value;
          probe_dist_next = rd.distance + 1'b1;
          idx_next        = idx + 1'b1;
        end else begin
          probe_dist_next = probe_dist + 1'b1;
          idx_next        = idx + 1'b1;
        end
      end

      rhkv_pkg::S_RESP: begin
        // Hand the result to the output register once it is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = rhkv_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rhkv_pkg::S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !rsp.ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rhkv_pkg::S_CLEAR;
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    probe_dist <= probe_dist_next;
    home       <= home_next;
    cur_key    <= cur_key_next;
    cur_val    <= cur_val_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (accept) begin
      op <= req.op;
    end
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= count;
    end
  end

endmodule
